FILE: sv/ptts_pkg.sv
`timescale 1ns / 1ps

package ptts_pkg;

    localparam int MAX_SLOTS = 8;
    localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int KIND_W    = 3;
    localparam int ID_W      = 4;
    localparam int PER_W     = 32;
    localparam int TICK_W    = 16;
    localparam int FIRE_W    = 8;
    localparam int CMP_W     = (CNT_W > ID_W) ? CNT_W : ID_W;
    localparam int STEP_W    = $clog2(PER_W);

    localparam logic [TICK_W-1:0] TICK_RST = TICK_W'(100);

    typedef enum logic [KIND_W-1:0] {
        K_TICK  = 3'd0,
        K_REG   = 3'd1,
        K_STOP  = 3'd2,
        K_START = 3'd3,
        K_SETP  = 3'd4
    } t_kind;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   slot_id;
        logic [PER_W-1:0]  period_ms;
        logic              has_body;
    } t_cmd;

    typedef struct packed {
        logic [FIRE_W-1:0] fire_mask;
        logic [ID_W-1:0]   assigned_id;
        logic              accepted;
        logic              slot_stopped;
    } t_result;

    // token walking down the slot chain, one cell per cycle
    typedef struct packed {
        logic              vld;
        logic              act;
        t_kind             kind;
        logic [IDX_W-1:0]  tgt;
        logic [PER_W-1:0]  period;
        logic [TICK_W-1:0] tick;
        logic [FIRE_W-1:0] mask;
        logic              stopped;
    } t_tok;

endpackage

FILE: sv/periodic_task_tick_scheduler.sv
`timescale 1ns / 1ps

// Periodic task tick scheduler: eight task slots in a row of cells.
// Command channel: drive i_cmd and raise start; the beat is taken on an edge
// where busy is low. Kinds: tick, register, stop, start, set period.
// Every command gives one result beat on o_result, marked by o_valid for a
// single cycle; the receiver cannot stall it and must take it then.
// A command token walks the cell row one slot per cycle. For a tick, stop,
// start or set period it is registered in r_tok, then in each cell of the
// row, and o_valid is registered from the last cell's token. A register
// command first runs the period through a bit-serial remainder unit (one
// bit per cycle) to check it is a multiple of the tick length, then walks
// the row. A register rejected up front skips the remainder.
// busy stays high from accept until the result cycle; one command at a time,
// the next beat can be taken at the edge that takes the result beat.
// Config channel: i_cfg_valid / o_cfg_ready with i_cfg_data, the tick length
// in ms; o_cfg_ready is always high, write only while busy is low.
// Reset (synchronous, active low) empties the table, stops all slots and
// loads a tick length of 100 ms.
module periodic_task_tick_scheduler (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  ptts_pkg::t_cmd              i_cmd,
    output logic                        o_valid,
    output ptts_pkg::t_result           o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ptts_pkg::TICK_W-1:0] i_cfg_data
);
    import ptts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_DIV   = 3'b010,
        S_CHAIN = 3'b100
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [TICK_W-1:0] r_tick;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [PER_W-1:0]  r_period;
    logic              r_acc;
    logic              n_acc;
    logic [ID_W-1:0]   r_aid;
    logic [ID_W-1:0]   n_aid;
    t_tok              r_tok;
    t_tok              n_tok;
    logic              r_valid;
    logic              n_valid;
    t_result           r_res;
    t_result           n_res;

    t_tok              w_tok [0:MAX_SLOTS];

    logic              accept;
    logic              id_ok;
    logic              reg_ok;
    logic              div_go;
    logic              div_done;
    logic              rem_zero;
    logic [IDX_W-1:0]  id_idx;
    logic [IDX_W-1:0]  cnt_idx;
    t_kind             cmd_kind;

    assign accept   = start && !busy;
    assign cmd_kind = t_kind'(i_cmd.kind);
    assign id_ok    = (i_cmd.slot_id != '0) &&
                      (CMP_W'(i_cmd.slot_id) <= CMP_W'(r_count));
    assign id_idx   = IDX_W'(CMP_W'(i_cmd.slot_id) - CMP_W'(1));
    assign cnt_idx  = IDX_W'(r_count);
    assign reg_ok   = i_cmd.has_body && (r_tick != '0) &&
                      (i_cmd.period_ms >= PER_W'(r_tick)) &&
                      (r_count < CNT_W'(MAX_SLOTS));
    assign div_go   = accept && (cmd_kind == K_REG) && reg_ok;

    ptts_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend (i_cmd.period_ms),
        .i_divisor  (r_tick),
        .o_done     (div_done),
        .o_rem_zero (rem_zero)
    );

    assign w_tok[0] = r_tok;

    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        ptts_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_acc         = r_acc;
        n_aid         = r_aid;
        n_valid       = 1'b0;
        n_res         = r_res;
        n_tok         = r_tok;
        n_tok.vld     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_tok.vld     = 1'b1;
                    n_tok.act     = 1'b0;
                    n_tok.kind    = cmd_kind;
                    n_tok.tgt     = id_idx;
                    n_tok.period  = i_cmd.period_ms;
                    n_tok.tick    = r_tick;
                    n_tok.mask    = '0;
                    n_tok.stopped = 1'b0;
                    n_aid         = '0;
                    n_acc         = 1'b0;
                    n_state       = S_CHAIN;
                    case (cmd_kind)
                        K_TICK: begin
                            n_tok.act = 1'b1;
                            n_acc     = 1'b1;
                        end
                        K_REG: begin
                            if (reg_ok) begin
                                n_tok.vld = 1'b0;
                                n_state   = S_DIV;
                            end
                        end
                        K_STOP, K_START, K_SETP: begin
                            n_tok.act = id_ok;
                            n_acc     = id_ok;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_tok.vld     = 1'b1;
                    n_tok.act     = rem_zero;
                    n_tok.kind    = K_REG;
                    n_tok.tgt     = cnt_idx;
                    n_tok.period  = r_period;
                    n_tok.tick    = r_tick;
                    n_tok.mask    = '0;
                    n_tok.stopped = 1'b0;
                    if (rem_zero) begin
                        n_acc   = 1'b1;
                        n_aid   = ID_W'(r_count + CNT_W'(1));
                        n_count = r_count + CNT_W'(1);
                    end
                    n_state = S_CHAIN;
                end
            end
            S_CHAIN: begin
                if (w_tok[MAX_SLOTS].vld) begin
                    n_valid            = 1'b1;
                    n_res.fire_mask    = w_tok[MAX_SLOTS].mask;
                    n_res.assigned_id  = r_aid;
                    n_res.accepted     = r_acc;
                    n_res.slot_stopped = w_tok[MAX_SLOTS].stopped;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_tick    <= TICK_RST;
            r_valid   <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_valid   <= n_valid;
            r_tok.vld <= n_tok.vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tick <= i_cfg_data;
            end
        end
        r_acc         <= n_acc;
        r_aid         <= n_aid;
        r_res         <= n_res;
        r_tok.act     <= n_tok.act;
        r_tok.kind    <= n_tok.kind;
        r_tok.tgt     <= n_tok.tgt;
        r_tok.period  <= n_tok.period;
        r_tok.tick    <= n_tok.tick;
        r_tok.mask    <= n_tok.mask;
        r_tok.stopped <= n_tok.stopped;
        if (accept) begin
            r_period <= i_cmd.period_ms;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_result    = r_res;
    assign o_cfg_ready = 1'b1;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SLOTS))
        else $error("slot count above table size");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back to back result beats");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after accept");

    a_idle_no_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_tok[MAX_SLOTS].vld)
        else $error("token left the chain while idle");

    a_id_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.assigned_id != '0)) |-> o_result.accepted)
        else $error("slot id given on a rejected register");

endmodule

FILE: sv/ptts_cell.sv
`timescale 1ns / 1ps

module ptts_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [ptts_pkg::IDX_W-1:0] i_idx,
    input  ptts_pkg::t_tok            i_tok,
    output ptts_pkg::t_tok            o_tok
);
    import ptts_pkg::*;

    logic              r_used;
    logic              r_en;
    logic [PER_W-1:0]  r_period;
    logic [PER_W-1:0]  r_elapsed;
    t_tok              r_tok;

    logic              n_used;
    logic              n_en;
    logic [PER_W-1:0]  n_period;
    logic [PER_W-1:0]  n_elapsed;
    t_tok              n_tok;

    logic              hit;
    logic              fire;
    logic [PER_W-1:0]  base;
    logic [PER_W:0]    sum;

    assign hit  = i_tok.vld && i_tok.act && (i_tok.tgt == i_idx);
    assign fire = r_en && (r_elapsed >= r_period);
    assign base = fire ? '0 : r_elapsed;
    assign sum  = {1'b0, base} + (PER_W + 1)'(i_tok.tick);

    always_comb begin
        n_used    = r_used;
        n_en      = r_en;
        n_period  = r_period;
        n_elapsed = r_elapsed;
        n_tok     = i_tok;
        if (i_tok.vld) begin
            case (i_tok.kind)
                K_TICK: begin
                    if (i_tok.act && r_used) begin
                        n_elapsed  = sum[PER_W] ? '1 : sum[PER_W-1:0];
                        n_tok.mask = i_tok.mask | (FIRE_W'(fire) << i_idx);
                    end
                end
                K_REG: begin
                    if (hit) begin
                        n_used    = 1'b1;
                        n_en      = 1'b1;
                        n_period  = i_tok.period;
                        n_elapsed = '0;
                    end
                end
                K_STOP, K_START: begin
                    if (hit) begin
                        n_en = (i_tok.kind == K_START);
                    end
                end
                K_SETP: begin
                    if (hit) begin
                        n_period      = i_tok.period;
                        n_tok.stopped = !r_en;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= 1'b0;
            r_en      <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_used    <= n_used;
            r_en      <= n_en;
            r_tok.vld <= n_tok.vld;
        end
        r_period          <= n_period;
        r_elapsed         <= n_elapsed;
        r_tok.act         <= n_tok.act;
        r_tok.kind        <= n_tok.kind;
        r_tok.tgt         <= n_tok.tgt;
        r_tok.period      <= n_tok.period;
        r_tok.tick        <= n_tok.tick;
        r_tok.mask        <= n_tok.mask;
        r_tok.stopped     <= n_tok.stopped;
    end

    assign o_tok = r_tok;

endmodule

FILE: sv/ptts_rem.sv
`timescale 1ns / 1ps

// restoring remainder, one dividend bit per cycle
module ptts_rem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ptts_pkg::PER_W-1:0]  i_dividend,
    input  logic [ptts_pkg::TICK_W-1:0] i_divisor,
    output logic                        o_done,
    output logic                        o_rem_zero
);
    import ptts_pkg::*;

    logic              r_run;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [TICK_W-1:0] r_rem;
    logic [TICK_W-1:0] r_div;
    logic [PER_W-1:0]  r_dvd;

    logic [TICK_W:0]   shifted;
    logic [TICK_W:0]   diff;
    logic [TICK_W-1:0] n_rem;

    assign shifted = {r_rem, r_dvd[PER_W-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign n_rem   = diff[TICK_W] ? shifted[TICK_W-1:0] : diff[TICK_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_run && (r_cnt == '0);
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_cnt == '0)) begin
                r_run <= 1'b0;
            end
        end
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_dvd <= i_dividend;
            r_cnt <= STEP_W'(PER_W - 1);
        end else if (r_run) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[PER_W-2:0], 1'b0};
            r_cnt <= r_cnt - STEP_W'(1);
        end
    end

    assign o_done     = r_done;
    assign o_rem_zero = (r_rem == '0);

endmodule
